>>> hw/rtl/ida_pkg.sv
// ----------------------------------------------------------------------------
// ida_pkg
// Shared sizes, codes and controller/datapath interface types of the
// interrupt ID bitmap allocator.
// ----------------------------------------------------------------------------
package ida_pkg;

	localparam int MAP_SIZE = 1024;
	localparam int WORD_W   = 32;
	localparam int NWORDS   = MAP_SIZE / WORD_W;
	localparam int WADDR_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int SLOT_W   = $clog2(MAP_SIZE);

	localparam int BASE_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int ID_W     = 11;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 1;

	// width of the saturated count, and of range arithmetic on IDs
	localparam int LIVE_W = (SLOT_W + 1 > COUNT_W) ? SLOT_W + 1 : COUNT_W;
	localparam int CMP_W  = LIVE_W + 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ID_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT = 1'b1;

	typedef struct packed {
		logic take;          // latch the input item
		logic scan_first;    // read map word 0
		logic scan_step;     // read next map word
		logic alloc_commit;  // set the found bit, record the grant
		logic free_rd;       // read the word holding the freed slot
		logic free_commit;   // clear the slot bit, record freed
		logic res_none;      // record none free
		logic res_ignored;   // record free ignored
		logic out_load;      // move the pending result to the output
	} ida_cmd_t;

	typedef struct packed {
		logic op_free;
		logic in_range;
		logic hit;
		logic last;
	} ida_status_t;

endpackage

>>> hw/rtl/ida_ctrl.sv
// ----------------------------------------------------------------------------
// ida_ctrl
// Sequencer of the allocator: accepts an item, drives the map scan or the
// free update, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ida_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  ida_pkg::ida_status_t sts,
	output ida_pkg::ida_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_SCAN  = 5'b00100,
		S_FCHK  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (!sts.op_free) begin
					cmd.scan_first = 1'b1;
					state_d        = S_SCAN;
				end else if (sts.in_range) begin
					cmd.free_rd = 1'b1;
					state_d     = S_FCHK;
				end else begin
					cmd.res_ignored = 1'b1;
					state_d         = S_OUT;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_OUT;
				end else if (sts.last) begin
					cmd.res_none = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FCHK: begin
				cmd.free_commit = 1'b1;
				state_d         = S_OUT;
			end
			S_OUT: begin
				// wait for the output register to empty
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/ida_dpath.sv
// ----------------------------------------------------------------------------
// ida_dpath
// Datapath of the allocator: configuration registers, the used-bit map as a
// word memory with per-row valid bits, first-free search over one word, and
// the result registers.
// ----------------------------------------------------------------------------
module ida_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ida_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ida_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                op,
	input  logic [ida_pkg::ID_W-1:0]            free_id,
	output logic [ida_pkg::ID_W-1:0]            granted_id,
	output logic [ida_pkg::STATUS_W-1:0]        status,
	input  ida_pkg::ida_cmd_t                   cmd,
	output ida_pkg::ida_status_t                sts
);

	localparam int WORD_W  = ida_pkg::WORD_W;
	localparam int WADDR_W = ida_pkg::WADDR_W;
	localparam int BIT_W   = ida_pkg::BIT_W;
	localparam int SLOT_W  = ida_pkg::SLOT_W;
	localparam int LIVE_W  = ida_pkg::LIVE_W;
	localparam int CMP_W   = ida_pkg::CMP_W;
	localparam int ID_W    = ida_pkg::ID_W;
	localparam int NWORDS  = ida_pkg::NWORDS;

	// configuration
	logic [ida_pkg::BASE_W-1:0]  base_q;
	logic [ida_pkg::COUNT_W-1:0] count_q;
	logic [LIVE_W-1:0]           live_n;

	// latched item
	logic                        op_q;
	logic [ID_W-1:0]             fid_q;

	// map storage
	logic [WORD_W-1:0]           mem [NWORDS];
	logic [NWORDS-1:0]           row_valid_q;
	logic [WORD_W-1:0]           rd_data_q;
	logic                        rd_rowv_q;
	logic [WADDR_W-1:0]          rd_w_q;
	logic [WADDR_W-1:0]          chk_w_q;

	// result registers
	logic [ID_W-1:0]             res_id_q;
	logic [ida_pkg::STATUS_W-1:0] res_st_q;
	logic [ID_W-1:0]             out_id_q;
	logic [ida_pkg::STATUS_W-1:0] out_st_q;

	logic [CMP_W-1:0]            fid_x, base_x, top_x, slot_x;
	logic [SLOT_W-1:0]           free_slot;
	logic [WADDR_W-1:0]          free_w;
	logic [BIT_W-1:0]            free_b;
	logic [WADDR_W-1:0]          rd_addr;
	logic                        rd_en;
	logic [WORD_W-1:0]           word;
	logic [WORD_W-1:0]           avail;
	logic [WORD_W-1:0]           lowest;
	logic [BIT_W-1:0]            hit_b;
	logic [CMP_W-1:0]            word_end;
	logic [SLOT_W-1:0]           hit_slot;
	logic [CMP_W-1:0]            grant_sum;
	logic                        wr_en;
	logic [WADDR_W-1:0]          wr_w;
	logic [WORD_W-1:0]           wr_data;

	assign live_n = (LIVE_W'(count_q) > LIVE_W'(ida_pkg::MAP_SIZE)) ?
		LIVE_W'(ida_pkg::MAP_SIZE) : LIVE_W'(count_q);

	// range check of the freed ID
	assign fid_x     = CMP_W'(fid_q);
	assign base_x    = CMP_W'(base_q);
	assign top_x     = base_x + CMP_W'(live_n);
	assign slot_x    = fid_x - base_x;
	assign free_slot = slot_x[SLOT_W-1:0];
	assign free_w    = WADDR_W'(free_slot >> BIT_W);
	assign free_b    = free_slot[BIT_W-1:0];

	assign word = rd_rowv_q ? rd_data_q : '0;

	// free bits of the current word that lie below the live count
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			avail[b] = !word[b] &&
				(CMP_W'({chk_w_q, BIT_W'(b)}) < CMP_W'(live_n));
		end
	end

	assign lowest = avail & (~avail + WORD_W'(1));

	always_comb begin
		hit_b = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (lowest[b]) begin
				hit_b = hit_b | BIT_W'(b);
			end
		end
	end

	assign hit_slot  = SLOT_W'({chk_w_q, hit_b});
	assign grant_sum = base_x + CMP_W'(hit_slot);
	assign word_end  = CMP_W'({chk_w_q, BIT_W'(0)}) + CMP_W'(WORD_W);

	assign sts.op_free  = (op_q == ida_pkg::OP_FREE);
	assign sts.in_range = (fid_x >= base_x) && (fid_x < top_x);
	assign sts.hit      = |avail;
	assign sts.last     = (word_end >= CMP_W'(live_n));

	// memory read port
	assign rd_en   = cmd.scan_first || cmd.scan_step || cmd.free_rd;
	assign rd_addr = cmd.free_rd ? free_w : (cmd.scan_first ? '0 : rd_w_q);

	// memory write port
	assign wr_en   = cmd.alloc_commit || cmd.free_commit;
	assign wr_w    = cmd.alloc_commit ? chk_w_q : free_w;
	assign wr_data = cmd.alloc_commit ? (word | lowest) :
		(word & ~(WORD_W'(1) << free_b));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_w] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= ida_pkg::BASE_W'(32);
			count_q     <= '0;
			row_valid_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ida_pkg::REG_ID_BASE:  base_q  <= cfg_data[ida_pkg::BASE_W-1:0];
					ida_pkg::REG_ID_COUNT: count_q <= cfg_data[ida_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (wr_en) begin
				row_valid_q[wr_w] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= op;
			fid_q <= free_id;
		end
		if (rd_en) begin
			rd_rowv_q <= row_valid_q[rd_addr];
		end
		// advance the scan pipeline: chk_w_q names the word in rd_data_q
		if (cmd.scan_first) begin
			chk_w_q <= '0;
			rd_w_q  <= WADDR_W'(1);
		end else if (cmd.scan_step) begin
			chk_w_q <= rd_w_q;
			rd_w_q  <= rd_w_q + WADDR_W'(1);
		end
		if (cmd.alloc_commit) begin
			res_id_q <= grant_sum[ID_W-1:0];
			res_st_q <= ida_pkg::ST_ALLOCATED;
		end else if (cmd.res_none) begin
			res_id_q <= '0;
			res_st_q <= ida_pkg::ST_NONE_FREE;
		end else if (cmd.free_commit) begin
			res_id_q <= '0;
			res_st_q <= ida_pkg::ST_FREED;
		end else if (cmd.res_ignored) begin
			res_id_q <= '0;
			res_st_q <= ida_pkg::ST_IGNORED;
		end
		if (cmd.out_load) begin
			out_id_q <= res_id_q;
			out_st_q <= res_st_q;
		end
	end

	assign granted_id = out_id_q;
	assign status     = out_st_q;

endmodule

>>> hw/rtl/interrupt_id_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// interrupt_id_bitmap_allocator
// First-fit allocator of interrupt IDs over a used-bit map.
// ----------------------------------------------------------------------------
// One item at a time. An allocate scans the map one 32-bit word per cycle
// through a single registered read port over the words covering n slots,
// n being id_count saturated to the map size; it stops at the first word
// holding a free slot. A free reads the word holding the slot and clears
// its bit, or is ignored with no read when the ID is outside base to base
// plus count. Each map row has a valid bit cleared at reset, so the map
// reads as all free right after reset with no clearing pass. A finished
// result waits in the output register while the next item is accepted.
module interrupt_id_bitmap_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ida_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ida_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [ida_pkg::ID_W-1:0]     free_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ida_pkg::ID_W-1:0]     granted_id,
	output logic [ida_pkg::STATUS_W-1:0] status
);

	ida_pkg::ida_cmd_t    cmd;
	ida_pkg::ida_status_t sts;

	ida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ida_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.free_id    (free_id),
		.granted_id (granted_id),
		.status     (status),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> tb/interrupt_id_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_id_bitmap_allocator_tb
// Drives allocate and free requests into the first-fit ID allocator under
// bursty input and a shifting output stall pattern. A directed table opens
// the run (reset state, range edges, double free, shrinking range). It is
// followed by a full-map fill, three fixed edge ranges and a series of
// randomly placed ranges. Each result is compared with the value in the
// table or with a first-fit model of the used-bit map kept here.
module interrupt_id_bitmap_allocator_tb;

	localparam int MAP_SIZE  = ida_pkg::MAP_SIZE;
	localparam int BASE_W    = ida_pkg::BASE_W;
	localparam int COUNT_W   = ida_pkg::COUNT_W;
	localparam int ID_W      = ida_pkg::ID_W;
	localparam int STATUS_W  = ida_pkg::STATUS_W;
	localparam int CFG_W     = ida_pkg::CFG_W;
	localparam int CFG_IDX_W = ida_pkg::CFG_IDX_W;

	localparam logic OP_ALLOC = ida_pkg::OP_ALLOC;
	localparam logic OP_FREE  = ida_pkg::OP_FREE;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = ida_pkg::ST_ALLOCATED;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = ida_pkg::ST_NONE_FREE;
	localparam logic [STATUS_W-1:0] ST_FREED     = ida_pkg::ST_FREED;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = ida_pkg::ST_IGNORED;

	localparam logic [CFG_IDX_W-1:0] REG_ID_BASE  = ida_pkg::REG_ID_BASE;
	localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT = ida_pkg::REG_ID_COUNT;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 48;

	localparam logic ROW_ITEM = 1'b0;
	localparam logic ROW_CFG  = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [CFG_IDX_W-1:0] idx;
		logic                 opv;
		logic [ID_W-1:0]      arg;
		logic                 typed;
		logic [ID_W-1:0]      eid;
		logic [STATUS_W-1:0]  est;
	} dir_row_t;

	typedef struct packed {
		logic [ID_W-1:0]     gid;
		logic [STATUS_W-1:0] st;
	} answer_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 op = OP_ALLOC;
	logic [ID_W-1:0]      free_id = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ID_W-1:0]      granted_id;
	logic [STATUS_W-1:0]  status;

	interrupt_id_bitmap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.free_id(free_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_id(granted_id),
		.status(status)
	);

	// mirror of the block's registers and used-bit map
	logic [BASE_W-1:0]  mir_base;
	logic [COUNT_W-1:0] mir_count;
	bit                 mir_used [MAP_SIZE];

	answer_t answers_due [$];
	answer_t seen;
	int      errors = 0;
	int      cycles = 0;
	int      n_items = 0;
	int      n_grant = 0;
	int      n_none = 0;
	int      n_freed = 0;
	int      n_ignored = 0;
	int      burst_left = 0;
	int      stall_tick = 0;
	int      stall_mode = 0;

	dir_row_t dir_tab [28] = '{
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd0,    ST_NONE_FREE},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd2047, 1'b1, 11'd0,    ST_IGNORED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd32,   1'b1, 11'd0,    ST_IGNORED},
		'{ROW_CFG,  REG_ID_COUNT, OP_ALLOC, 11'd2047, 1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_CFG,  REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd0,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd1,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1,    1'b1, 11'd0,    ST_FREED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1,    1'b1, 11'd0,    ST_FREED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd1,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1024, 1'b1, 11'd0,    ST_IGNORED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1023, 1'b1, 11'd0,    ST_FREED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd0,    1'b1, 11'd0,    ST_FREED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd0,    ST_ALLOCATED},
		'{ROW_CFG,  REG_ID_BASE,  OP_ALLOC, 11'd1023, 1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd1025, ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1022, 1'b1, 11'd0,    ST_IGNORED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1023, 1'b1, 11'd0,    ST_FREED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd1023, ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd2046, 1'b1, 11'd0,    ST_FREED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd2047, 1'b1, 11'd0,    ST_IGNORED},
		'{ROW_CFG,  REG_ID_COUNT, OP_ALLOC, 11'd2,    1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b1, 11'd0,    ST_NONE_FREE},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1025, 1'b1, 11'd0,    ST_IGNORED},
		'{ROW_CFG,  REG_ID_COUNT, OP_ALLOC, 11'd32,   1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_ALLOC, 11'd0,    1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_CFG,  REG_ID_COUNT, OP_ALLOC, 11'd0,    1'b0, 11'd0,    ST_ALLOCATED},
		'{ROW_ITEM, REG_ID_BASE,  OP_FREE,  11'd1023, 1'b1, 11'd0,    ST_IGNORED}
	};

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				answers_due.size());
			$display("interrupt_id_bitmap_allocator verification failed");
			$finish;
		end
	end

	// receiver: drive out_stall from one of four stall patterns, picked at random as stall_tick advances
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= ((stall_tick % 5) < 2);
		endcase
	end

	task automatic flag_mismatch(input string what);
		errors++;
		$display("MISMATCH @%0d: %s", cycles, what);
	endtask

	// result is taken at the next rising edge; values are settled here
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result id=%0d status=%0d",
					granted_id, status));
			end else begin
				seen = answers_due.pop_front();
				if (granted_id !== seen.gid)
					flag_mismatch($sformatf("granted_id %0d, want %0d (status %0d)",
						granted_id, seen.gid, seen.st));
				if (status !== seen.st)
					flag_mismatch($sformatf("status %0d, want %0d", status, seen.st));
				case (status)
					ST_ALLOCATED: n_grant++;
					ST_NONE_FREE: n_none++;
					ST_FREED:     n_freed++;
					default:      n_ignored++;
				endcase
			end
		end
	end

	function automatic answer_t first_fit_step(input logic o, input logic [ID_W-1:0] f);
		answer_t a;
		int      n;
		int      s;
		bit      found;
		a.gid = '0;
		found = 1'b0;
		n = (mir_count > MAP_SIZE) ? MAP_SIZE : int'(mir_count);
		if (o == OP_ALLOC) begin
			a.st = ST_NONE_FREE;
			for (s = 0; s < n && !found; s++) begin
				if (!mir_used[s]) begin
					mir_used[s] = 1'b1;
					a.gid = ID_W'(int'(mir_base) + s);
					a.st = ST_ALLOCATED;
					found = 1'b1;
				end
			end
		end else if (int'(f) < int'(mir_base) || int'(f) >= int'(mir_base) + n) begin
			a.st = ST_IGNORED;
		end else begin
			mir_used[int'(f) - int'(mir_base)] = 1'b0;
			a.st = ST_FREED;
		end
		return a;
	endfunction

	// present one item, hold it until taken, then book its answer
	task automatic offer(input logic o, input logic [ID_W-1:0] f, input logic typed,
			input answer_t typed_ans);
		answer_t a;
		bit      go;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		free_id <= f;
		do begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
		end while (!go);
		a = first_fit_step(o, f);
		answers_due.push_back(typed ? typed_ans : a);
		n_items++;
	endtask

	// write a register once every outstanding result has drained
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		in_valid <= 1'b0;
		burst_left = 0;
		while (answers_due.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ID_BASE)
			mir_base = val[BASE_W-1:0];
		else
			mir_count = val[COUNT_W-1:0];
	endtask

	task automatic churn_phase(input int base, input int cnt, input int items,
			input int alloc_pct);
		int              n;
		logic            o;
		logic [ID_W-1:0] f;
		set_reg(REG_ID_BASE, CFG_W'(base));
		set_reg(REG_ID_COUNT, CFG_W'(cnt));
		n = (cnt > MAP_SIZE) ? MAP_SIZE : cnt;
		repeat (items) begin
			o = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
			// mostly in range, one past the end included; otherwise anywhere
			if ($urandom_range(0, 99) < 75)
				f = ID_W'(base + $urandom_range(0, n));
			else
				f = ID_W'($urandom);
			offer(o, f, 1'b0, '0);
		end
	endtask

	initial begin
		int      i;
		int      p;
		int      cnt;
		answer_t ta;
		mir_base = 10'd32;
		mir_count = '0;
		for (i = 0; i < MAP_SIZE; i++) mir_used[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < $size(dir_tab); i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				set_reg(dir_tab[i].idx, dir_tab[i].arg);
			end else begin
				ta.gid = dir_tab[i].eid;
				ta.st = dir_tab[i].est;
				offer(dir_tab[i].opv, dir_tab[i].arg, dir_tab[i].typed, ta);
			end
		end

		// fill the whole map at the top of the ID space, then run past full
		churn_phase(1023, 1024, 1030, 100);

		for (p = 0; p < 10; p++) begin
			case (p)
				0: churn_phase(0, 1, 30, 50);
				1: churn_phase(1023, 2047, 30, 50);
				2: churn_phase(0, 0, 20, 50);
				default: begin
					cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 1024)
						: $urandom_range(1, 64);
					churn_phase($urandom_range(0, 1023), cnt, 30, 50);
				end
			endcase
		end

		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d grants, %0d none free, %0d frees, %0d ignored",
			n_items, n_grant, n_none, n_freed, n_ignored);
		$display("ranges swept from count 0 to saturated, base 0 to 1023, %0d mismatches",
			errors);
		if (errors == 0)
			$display("interrupt_id_bitmap_allocator verification clean");
		else
			$display("interrupt_id_bitmap_allocator verification failed");
		$finish;
	end

endmodule
